>>> hdl/aes_pkg.sv
// Package with the AES S-box and the round helper functions.
package aes_pkg;

  localparam int ROUND_COUNT = 10;
  localparam int KEY_WORDS = 4 * (ROUND_COUNT + 1);
  localparam int STAGES = ROUND_COUNT + 1;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW = 2'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One round on a 128-bit state, byte 0 in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int q = 0; q < 4; q++) t[4*c+q] = SBOX[b[4*((c+q)%4)+q]];
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = last ? t[i] : m[i];
    return r ^ rk;
  endfunction

endpackage

>>> hdl/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 encryptor.
// One block is taken per cycle while busy is low; each result passes
// through one stage for the first key addition and one per round, is
// marked by done for one cycle, and the receiver cannot stall. The round
// keys are rebuilt by a schedule with one stage per round key, so busy is
// high after reset or a key write until the last round key holds the new
// key; the first block that uses the new key is taken once busy is low
// again. Otherwise busy is low. Keys may only be written while no block
// is in flight.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        done,
  output logic [63:0] cipher_high,
  output logic [63:0] cipher_low,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic [127:0] rkey [aes_pkg::STAGES];
  logic [7:0]   rcon [aes_pkg::ROUND_COUNT];
  logic [3:0]   settle;
  logic [127:0] state [aes_pkg::STAGES];
  logic [aes_pkg::STAGES-1:0] valid;
  logic         accept;

  assign busy   = (settle != 4'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      settle   <= 4'(aes_pkg::STAGES);
    end else if (cfg_we && (cfg_index == aes_pkg::REG_KEY_HIGH ||
                            cfg_index == aes_pkg::REG_KEY_LOW)) begin
      if (cfg_index == aes_pkg::REG_KEY_HIGH) key_high <= cfg_data;
      else key_low <= cfg_data;
      settle <= 4'(aes_pkg::STAGES);
    end else if (settle != 4'd0) begin
      settle <= settle - 4'd1;
    end
  end

  // Key schedule: one registered stage per round key.
  always_ff @(posedge clk) begin
    rkey[0] <= {key_high, key_low};
    rcon[0] <= 8'h01;
    for (int k = 1; k < aes_pkg::STAGES; k++) begin
      logic [31:0] w0, w1, w2, w3, t;
      t  = aes_pkg::sub_word({rkey[k-1][23:0], rkey[k-1][31:24]}) ^ {rcon[k-1], 24'h0};
      w0 = rkey[k-1][127:96] ^ t;
      w1 = rkey[k-1][95:64] ^ w0;
      w2 = rkey[k-1][63:32] ^ w1;
      w3 = rkey[k-1][31:0] ^ w2;
      rkey[k] <= {w0, w1, w2, w3};
      if (k < aes_pkg::ROUND_COUNT) rcon[k] <= aes_pkg::xtime(rcon[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else valid <= {valid[aes_pkg::STAGES-2:0], accept};
  end

  always_ff @(posedge clk) begin
    state[0] <= {block_high, block_low} ^ rkey[0];
    for (int k = 1; k < aes_pkg::STAGES; k++)
      state[k] <= aes_pkg::aes_round(state[k-1], rkey[k], k == aes_pkg::ROUND_COUNT);
  end

  assign done        = valid[aes_pkg::STAGES-1];
  assign cipher_high = state[aes_pkg::STAGES-1][127:64];
  assign cipher_low  = state[aes_pkg::STAGES-1][63:0];

endmodule

>>> hdl/aes_checker.sv
// Port checker for the AES encryptor, bound to the top level.
module aes_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##11 done) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 11)) else $error("spurious result");
  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) |-> busy) else $error("busy low after reset");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done));
